// ===== sv/json_key_string_extractor_core_macros.svh =====
// Assertion macros shared by the extractor RTL.
`ifndef JSON_KEY_STRING_EXTRACTOR_CORE_MACROS_SVH
`define JSON_KEY_STRING_EXTRACTOR_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk, off during reset.
`define JKSE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, sampled on clk, off during reset.
`define JKSE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define JKSE_ASSERT_NOW(label, ante, cons, msg)
`define JKSE_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== sv/jkse_pkg.sv =====
`timescale 1ns / 1ps

package jkse_pkg;

  localparam int KEY_MAX   = 16;
  localparam int WIN_DEPTH = KEY_MAX + 2;
  localparam int LEN_W     = $clog2(KEY_MAX + 1);
  localparam int KIDX_W    = $clog2(KEY_MAX);
  localparam int FILL_W    = $clog2(WIN_DEPTH + 1);
  localparam int KEY_BITS  = 8 * KEY_MAX;

  typedef logic [7:0] byte_t;
  typedef byte_t [WIN_DEPTH-1:0] win_t;

  // register indexes on the config port
  localparam logic [1:0] REG_KEY_LOW  = 2'd0;
  localparam logic [1:0] REG_KEY_HIGH = 2'd1;
  localparam logic [1:0] REG_KEY_LEN  = 2'd2;

  // parser phases
  localparam logic [2:0] PH_SEARCH = 3'd0;
  localparam logic [2:0] PH_COLON  = 3'd1;
  localparam logic [2:0] PH_OPENQ  = 3'd2;
  localparam logic [2:0] PH_VALUE  = 3'd3;
  localparam logic [2:0] PH_ESCAPE = 3'd4;
  localparam logic [2:0] PH_DONE   = 3'd5;

  // status codes
  localparam logic [2:0] ST_CLOSED  = 3'd0;
  localparam logic [2:0] ST_UNTERM  = 3'd1;
  localparam logic [2:0] ST_NOKEY   = 3'd2;
  localparam logic [2:0] ST_NOCOLON = 3'd3;
  localparam logic [2:0] ST_NOQUOTE = 3'd4;

  localparam byte_t CH_QUOTE = 8'h22;
  localparam byte_t CH_COLON = 8'h3A;
  localparam byte_t CH_BSL   = 8'h5C;
  localparam byte_t CH_SPACE = 8'h20;
  localparam byte_t CH_TAB   = 8'h09;
  localparam byte_t CH_CR    = 8'h0D;
  localparam byte_t CH_LF    = 8'h0A;
  localparam byte_t CH_SLASH = 8'h2F;
  localparam byte_t CH_N     = 8'h6E;
  localparam byte_t CH_T     = 8'h74;

  typedef struct packed {
    win_t                 pattern;
    logic [WIN_DEPTH-1:0] mask;
    logic [FILL_W-1:0]    need;
  } key_pat_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } win_ctl_t;

  typedef struct packed {
    logic       has_result;
    byte_t      value_byte;
    logic       value_byte_valid;
    logic       run_last;
    logic [2:0] status;
  } result_t;

  function automatic logic is_ws(input byte_t c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic result_t mk_result(input byte_t b, input logic vld, input logic last,
                                        input logic [2:0] st);
    result_t r;
    r.has_result       = 1'b1;
    r.value_byte       = vld ? b : 8'h00;
    r.value_byte_valid = vld;
    r.run_last         = last;
    r.status           = last ? st : ST_CLOSED;
    return r;
  endfunction

endpackage

// ===== sv/jkse_in_if.sv =====
`timescale 1ns / 1ps

interface jkse_in_if;
  logic               valid;
  logic               ready;
  jkse_pkg::byte_t    text_byte;
  logic               end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

// ===== sv/jkse_out_if.sv =====
`timescale 1ns / 1ps

interface jkse_out_if;
  logic            valid;
  logic            ready;
  jkse_pkg::byte_t value_byte;
  logic            value_byte_valid;
  logic            run_last;
  logic [2:0]      status;

  modport source (output valid, output value_byte, output value_byte_valid,
                  output run_last, output status, input ready);
  modport sink   (input valid, input value_byte, input value_byte_valid,
                  input run_last, input status, output ready);
endinterface

// ===== sv/jkse_cfg_if.sv =====
`timescale 1ns / 1ps

interface jkse_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/jkse_cfg_regs.sv =====
`timescale 1ns / 1ps

module jkse_cfg_regs (
  input  logic               clk,
  input  logic               rst_n,
  jkse_cfg_if.sink           cfg_ch,
  output jkse_pkg::key_pat_t key_pat
);

  logic [63:0]                  key_low_r;
  logic [63:0]                  key_high_r;
  logic [jkse_pkg::LEN_W-1:0]   key_len_r;
  logic [jkse_pkg::KEY_BITS-1:0] key_all;
  logic [jkse_pkg::FILL_W-1:0]  n_bytes;
  logic [jkse_pkg::FILL_W-1:0]  kpos;
  logic [4:0]                   len_in;

  assign cfg_ch.ready = 1'b1;
  assign len_in       = cfg_ch.data[4:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= '0;
      key_high_r <= '0;
      key_len_r  <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        jkse_pkg::REG_KEY_LOW:  key_low_r  <= cfg_ch.data;
        jkse_pkg::REG_KEY_HIGH: key_high_r <= cfg_ch.data;
        jkse_pkg::REG_KEY_LEN: begin
          if (len_in > 5'(jkse_pkg::KEY_MAX))
            key_len_r <= jkse_pkg::LEN_W'(jkse_pkg::KEY_MAX);
          else
            key_len_r <= jkse_pkg::LEN_W'(len_in);
        end
        default: ;
      endcase
    end
  end

  assign key_all = {key_high_r, key_low_r};
  // pattern is the quoted key, window order: index 0 holds the closing quote
  assign n_bytes = jkse_pkg::FILL_W'(key_len_r) + jkse_pkg::FILL_W'(2);

  always_comb begin
    kpos            = '0;
    key_pat.need    = n_bytes;
    key_pat.mask    = '0;
    key_pat.pattern = '0;
    for (int j = 0; j < jkse_pkg::WIN_DEPTH; j++) begin
      kpos = n_bytes - jkse_pkg::FILL_W'(j) - jkse_pkg::FILL_W'(2);
      if (jkse_pkg::FILL_W'(j) < n_bytes) begin
        key_pat.mask[j] = 1'b1;
        if (j == 0 || jkse_pkg::FILL_W'(j) == n_bytes - jkse_pkg::FILL_W'(1))
          key_pat.pattern[j] = jkse_pkg::CH_QUOTE;
        else
          key_pat.pattern[j] = key_all[8*kpos[jkse_pkg::KIDX_W-1:0] +: 8];
      end
    end
  end

endmodule

// ===== sv/jkse_window.sv =====
`timescale 1ns / 1ps

module jkse_window (
  input  logic               clk,
  input  logic               rst_n,
  input  jkse_pkg::byte_t    text_byte,
  input  jkse_pkg::win_ctl_t ctl,
  input  jkse_pkg::key_pat_t key_pat,
  output logic               match
);

  jkse_pkg::win_t              window_r;
  jkse_pkg::win_t              window_nxt;
  logic [jkse_pkg::FILL_W-1:0] fill_r;
  logic [jkse_pkg::FILL_W-1:0] fill_nxt;
  logic [jkse_pkg::WIN_DEPTH-1:0] hit;

  // window as it stands once this byte is shifted in; [0] is the newest
  assign window_nxt = {window_r[jkse_pkg::WIN_DEPTH-2:0], text_byte};
  assign fill_nxt   = (fill_r == jkse_pkg::FILL_W'(jkse_pkg::WIN_DEPTH)) ? fill_r
                                                                         : fill_r + 1'b1;

  always_comb begin
    for (int j = 0; j < jkse_pkg::WIN_DEPTH; j++)
      hit[j] = !key_pat.mask[j] || (window_nxt[j] == key_pat.pattern[j]);
  end

  assign match = (fill_nxt >= key_pat.need) && (&hit);

  always_ff @(posedge clk) begin
    if (ctl.shift)
      window_r <= window_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear)
      fill_r <= '0;
    else if (ctl.shift)
      fill_r <= fill_nxt;
  end

endmodule

// ===== sv/jkse_parser.sv =====
`timescale 1ns / 1ps

module jkse_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               advance,
  input  jkse_pkg::byte_t    text_byte,
  input  logic               end_of_text,
  input  logic               match,
  output jkse_pkg::win_ctl_t ctl,
  output jkse_pkg::result_t  res
);

  logic [2:0]      phase_r;
  logic [2:0]      phase_nxt;
  jkse_pkg::byte_t esc_byte;

  assign ctl.shift = advance && (phase_r == jkse_pkg::PH_SEARCH);
  assign ctl.clear = advance && end_of_text;

  always_comb begin
    case (text_byte)
      jkse_pkg::CH_N: esc_byte = jkse_pkg::CH_LF;
      jkse_pkg::CH_T: esc_byte = jkse_pkg::CH_TAB;
      default:        esc_byte = text_byte;
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    res       = '0;
    case (phase_r)
      jkse_pkg::PH_SEARCH: begin
        if (match) begin
          phase_nxt = jkse_pkg::PH_COLON;
          if (end_of_text)
            res = jkse_pkg::mk_result(8'h00, 1'b0, 1'b1, jkse_pkg::ST_NOCOLON);
        end else if (end_of_text) begin
          res = jkse_pkg::mk_result(8'h00, 1'b0, 1'b1, jkse_pkg::ST_NOKEY);
        end
      end
      jkse_pkg::PH_COLON: begin
        if (text_byte == jkse_pkg::CH_COLON) begin
          phase_nxt = jkse_pkg::PH_OPENQ;
          if (end_of_text)
            res = jkse_pkg::mk_result(8'h00, 1'b0, 1'b1, jkse_pkg::ST_NOQUOTE);
        end else if (!jkse_pkg::is_ws(text_byte)) begin
          phase_nxt = jkse_pkg::PH_DONE;
          res = jkse_pkg::mk_result(8'h00, 1'b0, 1'b1, jkse_pkg::ST_NOCOLON);
        end else if (end_of_text) begin
          res = jkse_pkg::mk_result(8'h00, 1'b0, 1'b1, jkse_pkg::ST_NOCOLON);
        end
      end
      jkse_pkg::PH_OPENQ: begin
        if (text_byte == jkse_pkg::CH_QUOTE) begin
          phase_nxt = jkse_pkg::PH_VALUE;
          if (end_of_text)
            res = jkse_pkg::mk_result(8'h00, 1'b0, 1'b1, jkse_pkg::ST_UNTERM);
        end else if (!jkse_pkg::is_ws(text_byte)) begin
          phase_nxt = jkse_pkg::PH_DONE;
          res = jkse_pkg::mk_result(8'h00, 1'b0, 1'b1, jkse_pkg::ST_NOQUOTE);
        end else if (end_of_text) begin
          res = jkse_pkg::mk_result(8'h00, 1'b0, 1'b1, jkse_pkg::ST_NOQUOTE);
        end
      end
      jkse_pkg::PH_VALUE: begin
        if (text_byte == jkse_pkg::CH_QUOTE) begin
          phase_nxt = jkse_pkg::PH_DONE;
          res = jkse_pkg::mk_result(8'h00, 1'b0, 1'b1, jkse_pkg::ST_CLOSED);
        end else if (text_byte == jkse_pkg::CH_BSL) begin
          // a lone backslash on the last beat goes out as is
          if (end_of_text)
            res = jkse_pkg::mk_result(text_byte, 1'b1, 1'b1, jkse_pkg::ST_UNTERM);
          else
            phase_nxt = jkse_pkg::PH_ESCAPE;
        end else begin
          res = jkse_pkg::mk_result(text_byte, 1'b1, end_of_text, jkse_pkg::ST_UNTERM);
        end
      end
      jkse_pkg::PH_ESCAPE: begin
        phase_nxt = jkse_pkg::PH_VALUE;
        res = jkse_pkg::mk_result(esc_byte, 1'b1, end_of_text, jkse_pkg::ST_UNTERM);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      phase_r <= jkse_pkg::PH_SEARCH;
    else if (advance)
      phase_r <= end_of_text ? jkse_pkg::PH_SEARCH : phase_nxt;
  end

endmodule

// ===== sv/json_key_string_extractor_core.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Payload                                          Handshake
// in_ch    in   text_byte[8], end_of_text                        valid/ready
// out_ch   out  value_byte[8], value_byte_valid, run_last, status[3]  valid/ready
// cfg_ch   in   index[2], data[64]                               valid/ready, ready=1
//
// One text byte per cycle sustained while out_ch is not stalled; a beat taken on in_ch that
// yields a result passes the input register, then the result register, before out_ch shows it.
// Key compare and phase update sit between those two registers.
// rst_n is synchronous; it clears the phase, window fill and key registers.
// A held result on out_ch stalls the input register, and in_ch drops ready
// only once that register is also full.

`include "json_key_string_extractor_core_macros.svh"

module json_key_string_extractor_core (
  input  logic       clk,
  input  logic       rst_n,
  jkse_in_if.sink    in_ch,
  jkse_out_if.source out_ch,
  jkse_cfg_if.sink   cfg_ch
);

  logic               in_valid_r;
  jkse_pkg::byte_t    in_byte_r;
  logic               in_eot_r;
  logic               advance;
  logic               out_valid_r;
  jkse_pkg::result_t  out_r;
  jkse_pkg::result_t  res;
  jkse_pkg::win_ctl_t win_ctl;
  jkse_pkg::key_pat_t key_pat;
  logic               match;

  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n)
      in_valid_r <= 1'b0;
    else if (in_ch.ready)
      in_valid_r <= in_ch.valid;
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_r <= in_ch.text_byte;
      in_eot_r  <= in_ch.end_of_text;
    end
  end

  jkse_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_ch  (cfg_ch),
    .key_pat (key_pat)
  );

  jkse_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .text_byte (in_byte_r),
    .ctl       (win_ctl),
    .key_pat   (key_pat),
    .match     (match)
  );

  jkse_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (advance),
    .text_byte   (in_byte_r),
    .end_of_text (in_eot_r),
    .match       (match),
    .ctl         (win_ctl),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n)
      out_valid_r <= 1'b0;
    else if (advance)
      out_valid_r <= res.has_result;
    else if (out_ch.ready)
      out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (advance && res.has_result)
      out_r <= res;
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.value_byte       = out_r.value_byte;
  assign out_ch.value_byte_valid = out_r.value_byte_valid;
  assign out_ch.run_last         = out_r.run_last;
  assign out_ch.status           = out_r.status;

  `JKSE_ASSERT_NOW(a_status_only_on_last, out_valid_r && !out_r.run_last,
                   out_r.status == jkse_pkg::ST_CLOSED, "status set on a non-final beat")
  `JKSE_ASSERT_NOW(a_byte_zero_when_empty, out_valid_r && !out_r.value_byte_valid,
                   out_r.value_byte == 8'h00, "value byte nonzero without value_byte_valid")
  `JKSE_ASSERT_NOW(a_status_in_range, out_valid_r,
                   out_r.status == jkse_pkg::ST_CLOSED || out_r.status == jkse_pkg::ST_UNTERM ||
                   out_r.status == jkse_pkg::ST_NOKEY || out_r.status == jkse_pkg::ST_NOCOLON ||
                   out_r.status == jkse_pkg::ST_NOQUOTE, "status code out of range")
  `JKSE_ASSERT_NEXT(a_in_reg_held, in_valid_r && !advance,
                    in_valid_r && $stable(in_byte_r) && $stable(in_eot_r),
                    "stalled input register lost its beat")

endmodule
